[sv/fsim_pkg.sv]
// ============================================================================
// fsim_pkg: shared definitions for the flow-shop insertion makespan engine
// Field widths, command and status codes, and the control word that drives
// the shared completion-time cell.
// ============================================================================
package fsim_pkg;

    localparam int CMD_W  = 3;
    localparam int JOB_W  = 6;
    localparam int MACH_W = 5;
    localparam int TIME_W = 16;
    localparam int POS_W  = 7;
    localparam int SPAN_W = 23;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 6;

    localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MAKESPAN = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BEST     = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic valid;
        logic first_row;
        logic first_col;
        logic job_ok;
    } t_cell_ctl;

endpackage

[sv/fsim_cmd_if.sv]
// ============================================================================
// fsim_cmd_if: command channel
// Valid/ready channel that carries one command item per transfer.
// ============================================================================
interface fsim_cmd_if;
    import fsim_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [JOB_W-1:0]  job_id;
    logic [MACH_W-1:0] machine_index;
    logic [TIME_W-1:0] time_value;
    logic [POS_W-1:0]  position;

    modport source (
        output valid, command, job_id, machine_index, time_value, position,
        input  ready
    );
    modport sink (
        input  valid, command, job_id, machine_index, time_value, position,
        output ready
    );
endinterface

[sv/fsim_res_if.sv]
// ============================================================================
// fsim_res_if: result channel
// Valid/ready channel that carries one result item per transfer.
// ============================================================================
interface fsim_res_if;
    import fsim_pkg::*;

    logic              valid;
    logic              ready;
    logic [SPAN_W-1:0] makespan;
    logic [POS_W-1:0]  best_position;
    logic [SPAN_W-1:0] worst_makespan;
    logic [STAT_W-1:0] status;

    modport source (
        output valid, makespan, best_position, worst_makespan, status,
        input  ready
    );
    modport sink (
        input  valid, makespan, best_position, worst_makespan, status,
        output ready
    );
endinterface

[sv/fsim_time_mem.sv]
// ============================================================================
// fsim_time_mem: processing time table
// Single write port, single read port, registered read data.
// ============================================================================
module fsim_time_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [fsim_pkg::TIME_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [fsim_pkg::TIME_W-1:0] o_rdata
);
    import fsim_pkg::*;

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

[sv/fsim_cell.sv]
// ============================================================================
// fsim_cell: shared completion-time unit
// Holds the completion row and evaluates one cell per cycle:
// C = max(row entry, previous stage) + time, written back into the row.
// ============================================================================
module fsim_cell #(
    parameter  int MAX_MACHINES = 32,
    parameter  int ROW_W        = 23,
    localparam int RIX_W        = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fsim_pkg::t_cell_ctl         i_ctl,
    input  logic [RIX_W-1:0]            i_idx,
    input  logic [fsim_pkg::TIME_W-1:0] i_time,
    output logic [ROW_W-1:0]            o_last,
    output logic                        o_busy
);
    import fsim_pkg::*;

    logic [ROW_W-1:0] r_row [MAX_MACHINES];
    logic [ROW_W-1:0] r_row_q;
    logic [ROW_W-1:0] r_prev;
    t_cell_ctl        r_ctl;
    logic [RIX_W-1:0] r_idx;

    logic [ROW_W-1:0] above;
    logic [ROW_W-1:0] left;
    logic [ROW_W-1:0] start;
    logic [ROW_W-1:0] sum;

    always_comb begin
        above = r_ctl.first_row ? '0 : r_row_q;
        left  = r_ctl.first_col ? '0 : r_prev;
        start = (above > left) ? above : left;
        sum   = start + (r_ctl.job_ok ? ROW_W'(i_time) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_row_q <= r_row[i_idx];
        end
        if (r_ctl.valid) begin
            r_row[r_idx] <= sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_prev <= '0;
        end else begin
            r_ctl <= i_ctl;
            if (r_ctl.valid) begin
                r_prev <= sum;
            end
        end
        r_idx <= i_idx;
    end

    assign o_last = r_prev;
    assign o_busy = r_ctl.valid;

endmodule

[sv/flow_shop_insertion_makespan_core.sv]
// ============================================================================
// flow_shop_insertion_makespan_core: permutation flow-shop makespan engine
// Keeps a processing time table and a job sequence, edits the sequence and
// evaluates makespans, including a search over every insertion slot.
//
//   Port           Dir  Kind         Content
//   i_cmd          in   valid/ready  command, job_id, machine_index,
//                                    time_value, position
//   o_res          out  valid/ready  makespan, best_position,
//                                    worst_makespan, status
//   i_cfg_wr_en    in   write        machine_count in i_cfg_wr_data
//
// Insert and remove shift the sequence one entry at a time through a read
// state and a write state. Makespan walks every job/stage cell of the
// sequence; best insertion repeats that walk once for each insertion slot.
// One shared cell unit evaluates one job/stage cell per cycle.
// i_cmd is ready only in the idle state; a finished result waits in the
// output register, and the next command is taken while it waits. A later
// result holds the engine in its final state until that register frees.
// Reset is synchronous; the time table and sequence store are not cleared.
// ============================================================================
module flow_shop_insertion_makespan_core #(
    parameter int MAX_JOBS     = 64,
    parameter int MAX_MACHINES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [fsim_pkg::CFG_W-1:0] i_cfg_wr_data,
    fsim_cmd_if.sink                   i_cmd,
    fsim_res_if.source                 o_res
);
    import fsim_pkg::*;

    localparam int SIX_W = $clog2(MAX_JOBS);
    localparam int LEN_W = $clog2(MAX_JOBS + 1);
    localparam int TAW   = $clog2(MAX_JOBS * MAX_MACHINES);
    localparam int M_W   = $clog2(MAX_MACHINES + 1);
    localparam int RIX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int ROW_W = $clog2((MAX_JOBS + MAX_MACHINES) * 65535 + 1);
    localparam int CW    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SHIFT_RD, S_SHIFT_WR, S_ROW_RD, S_ROW_SEL,
        S_CELLS, S_EVAL_END, S_FINISH
    } t_state;

    t_state             r_state;
    logic [CMD_W-1:0]   r_cmd;
    logic [JOB_W-1:0]   r_job;
    logic [MACH_W-1:0]  r_mach;
    logic [TIME_W-1:0]  r_tval;
    logic [POS_W-1:0]   r_pos;
    logic [LEN_W-1:0]   r_len;
    logic [CFG_W-1:0]   r_mcnt;
    logic               r_extra;
    logic [LEN_W-1:0]   r_ins;
    logic [LEN_W-1:0]   r_k;
    logic [LEN_W-1:0]   r_sk;
    logic [JOB_W-1:0]   r_cur;
    logic [M_W-1:0]     r_jr;
    logic               r_first_row;
    logic [ROW_W-1:0]   r_span;
    logic [LEN_W-1:0]   r_best;
    logic [ROW_W-1:0]   r_worst;
    logic [STAT_W-1:0]  r_status;
    logic               r_out_valid;
    logic [SPAN_W-1:0]  r_out_span;
    logic [POS_W-1:0]   r_out_best;
    logic [SPAN_W-1:0]  r_out_worst;
    logic [STAT_W-1:0]  r_out_status;

    logic [JOB_W-1:0]   r_seq [MAX_JOBS];
    logic [JOB_W-1:0]   r_seq_q;

    logic [M_W-1:0]     stages;
    logic               job_ok;
    logic               mach_ok;
    logic               cur_ok;
    logic               full;
    logic [CW-1:0]      pos_x;
    logic [CW-1:0]      len_x;
    logic [CW-1:0]      sk_x;
    logic               last_row;
    logic               row_done;
    logic               seq_we;
    logic [SIX_W-1:0]   seq_waddr;
    logic [JOB_W-1:0]   seq_wdata;
    logic               seq_re;
    logic [SIX_W-1:0]   seq_raddr;
    logic               time_we;
    logic [TAW-1:0]     time_waddr;
    logic [TAW-1:0]     time_raddr;
    logic [TIME_W-1:0]  time_q;
    t_cell_ctl          cell_ctl;
    logic [ROW_W-1:0]   cell_last;
    logic               cell_busy;
    t_state             n_dec_state;
    logic [STAT_W-1:0]  n_dec_status;

    always_comb begin
        if (r_mcnt == '0) begin
            stages = M_W'(1);
        end else if (int'(r_mcnt) > MAX_MACHINES) begin
            stages = M_W'(MAX_MACHINES);
        end else begin
            stages = M_W'(r_mcnt);
        end
    end

    assign job_ok   = int'(r_job) < MAX_JOBS;
    assign mach_ok  = int'(r_mach) < MAX_MACHINES;
    assign cur_ok   = int'(r_cur) < MAX_JOBS;
    assign full     = int'(r_len) >= MAX_JOBS;
    assign pos_x    = CW'(r_pos);
    assign len_x    = CW'(r_len);
    assign sk_x     = CW'(r_sk);
    assign last_row = (CW'(r_k) + CW'(1)) == (len_x + CW'(r_extra));
    assign row_done = (r_jr == stages) && !cell_busy;

    always_comb begin
        n_dec_state  = S_FINISH;
        n_dec_status = ST_OK;
        case (r_cmd)
            CMD_WRITE: begin
                if (!(job_ok && mach_ok)) begin
                    n_dec_status = ST_RANGE;
                end
            end
            CMD_APPEND: begin
                if (full) begin
                    n_dec_status = ST_FULL;
                end
            end
            CMD_INSERT: begin
                if (full) begin
                    n_dec_status = ST_FULL;
                end else if (pos_x > len_x) begin
                    n_dec_status = ST_RANGE;
                end else begin
                    n_dec_state = S_SHIFT_RD;
                end
            end
            CMD_REMOVE: begin
                if (pos_x >= len_x) begin
                    n_dec_status = ST_RANGE;
                end else begin
                    n_dec_state = S_SHIFT_RD;
                end
            end
            CMD_MAKESPAN: begin
                if (r_len != '0) begin
                    n_dec_state = S_ROW_RD;
                end
            end
            CMD_BEST: begin
                if (full) begin
                    n_dec_status = ST_FULL;
                end else begin
                    n_dec_state = S_ROW_RD;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        seq_we    = 1'b0;
        seq_waddr = r_len[SIX_W-1:0];
        seq_wdata = r_job;
        seq_re    = 1'b0;
        seq_raddr = r_k[SIX_W-1:0];
        case (r_state)
            S_DECODE: begin
                seq_we = (r_cmd == CMD_APPEND) && !full;
            end
            S_SHIFT_RD: begin
                if (r_cmd == CMD_INSERT) begin
                    if (sk_x == pos_x) begin
                        seq_we    = 1'b1;
                        seq_waddr = r_sk[SIX_W-1:0];
                    end else begin
                        seq_re    = 1'b1;
                        seq_raddr = SIX_W'(r_sk - LEN_W'(1));
                    end
                end else begin
                    seq_re    = (sk_x + CW'(1)) < len_x;
                    seq_raddr = SIX_W'(r_sk + LEN_W'(1));
                end
            end
            S_SHIFT_WR: begin
                seq_we    = 1'b1;
                seq_waddr = r_sk[SIX_W-1:0];
                seq_wdata = r_seq_q;
            end
            S_ROW_RD: begin
                seq_re = 1'b1;
                if (r_extra && (r_k > r_ins)) begin
                    seq_raddr = SIX_W'(r_k - LEN_W'(1));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (seq_we) begin
            r_seq[seq_waddr] <= seq_wdata;
        end
        if (seq_re) begin
            r_seq_q <= r_seq[seq_raddr];
        end
    end

    assign time_we    = (r_state == S_DECODE) && (r_cmd == CMD_WRITE) && job_ok && mach_ok;
    assign time_waddr = TAW'(TAW'(r_job) * TAW'(MAX_MACHINES) + TAW'(r_mach));
    assign time_raddr = TAW'(TAW'(r_cur) * TAW'(MAX_MACHINES) + TAW'(r_jr));

    always_comb begin
        cell_ctl.valid     = (r_state == S_CELLS) && (r_jr < stages);
        cell_ctl.first_row = r_first_row;
        cell_ctl.first_col = (r_jr == '0);
        cell_ctl.job_ok    = cur_ok;
    end

    fsim_time_mem #(
        .DEPTH (MAX_JOBS * MAX_MACHINES),
        .AW    (TAW)
    ) u_time_mem (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (time_waddr),
        .i_wdata (r_tval),
        .i_re    (cell_ctl.valid),
        .i_raddr (time_raddr),
        .o_rdata (time_q)
    );

    fsim_cell #(
        .MAX_MACHINES (MAX_MACHINES),
        .ROW_W        (ROW_W)
    ) u_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cell_ctl),
        .i_idx   (r_jr[RIX_W-1:0]),
        .i_time  (time_q),
        .o_last  (cell_last),
        .o_busy  (cell_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_mcnt      <= CFG_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mcnt <= i_cfg_wr_data;
            end
            if (r_out_valid && o_res.ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= i_cmd.command;
                        r_job   <= i_cmd.job_id;
                        r_mach  <= i_cmd.machine_index;
                        r_tval  <= i_cmd.time_value;
                        r_pos   <= i_cmd.position;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_span      <= '0;
                    r_best      <= '0;
                    r_worst     <= '0;
                    r_status    <= n_dec_status;
                    r_k         <= '0;
                    r_ins       <= '0;
                    r_first_row <= 1'b1;
                    r_state     <= n_dec_state;
                    case (r_cmd)
                        CMD_CLEAR: begin
                            r_len <= '0;
                        end
                        CMD_APPEND: begin
                            if (!full) begin
                                r_len <= r_len + LEN_W'(1);
                            end
                        end
                        CMD_INSERT: begin
                            r_sk <= r_len;
                        end
                        CMD_REMOVE: begin
                            r_sk <= LEN_W'(r_pos);
                        end
                        CMD_MAKESPAN: begin
                            r_extra <= 1'b0;
                        end
                        CMD_BEST: begin
                            r_extra <= 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                S_SHIFT_RD: begin
                    if (r_cmd == CMD_INSERT) begin
                        if (sk_x == pos_x) begin
                            r_len   <= r_len + LEN_W'(1);
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_SHIFT_WR;
                        end
                    end else if ((sk_x + CW'(1)) >= len_x) begin
                        r_len   <= r_len - LEN_W'(1);
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    if (r_cmd == CMD_INSERT) begin
                        r_sk <= r_sk - LEN_W'(1);
                    end else begin
                        r_sk <= r_sk + LEN_W'(1);
                    end
                    r_state <= S_SHIFT_RD;
                end
                S_ROW_RD: begin
                    r_state <= S_ROW_SEL;
                end
                S_ROW_SEL: begin
                    if (r_extra && (r_k == r_ins)) begin
                        r_cur <= r_job;
                    end else begin
                        r_cur <= r_seq_q;
                    end
                    r_jr    <= '0;
                    r_state <= S_CELLS;
                end
                S_CELLS: begin
                    if (r_jr < stages) begin
                        r_jr <= r_jr + M_W'(1);
                    end else if (row_done) begin
                        r_first_row <= 1'b0;
                        r_k         <= r_k + LEN_W'(1);
                        r_state     <= last_row ? S_EVAL_END : S_ROW_RD;
                    end
                end
                S_EVAL_END: begin
                    if (!r_extra) begin
                        r_span  <= cell_last;
                        r_state <= S_FINISH;
                    end else begin
                        if ((r_ins == '0) || (cell_last < r_span)) begin
                            r_span <= cell_last;
                            r_best <= r_ins;
                        end
                        if (cell_last > r_worst) begin
                            r_worst <= cell_last;
                        end
                        if (r_ins == r_len) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_ins       <= r_ins + LEN_W'(1);
                            r_k         <= '0;
                            r_first_row <= 1'b1;
                            r_state     <= S_ROW_RD;
                        end
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_span   <= SPAN_W'(r_span);
                        r_out_best   <= POS_W'(r_best);
                        r_out_worst  <= SPAN_W'(r_worst);
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.makespan       = r_out_span;
    assign o_res.best_position  = r_out_best;
    assign o_res.worst_makespan = r_out_worst;
    assign o_res.status         = r_out_status;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_len) <= MAX_JOBS)
        else $error("Sequence length exceeds its capacity.");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state == S_DECODE))
        else $error("An accepted command did not enter decode.");

    a_seq_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_we |-> ((r_state == S_DECODE) || (r_state == S_SHIFT_RD)
                    || (r_state == S_SHIFT_WR)))
        else $error("Sequence store written outside an edit command.");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != ST_OK))
            |-> ((o_res.makespan == '0) && (o_res.worst_makespan == '0)))
        else $error("A failed command reported a nonzero makespan.");

    a_cell_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_busy |-> (r_state == S_CELLS))
        else $error("Cell unit active outside the evaluation loop.");

endmodule

[bench/flow_shop_insertion_makespan_core_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// flow_shop_insertion_makespan_core_tb: self-checking bench for the engine
// Drives commands and stage counts into the flow-shop engine and mirrors the
// time table and job sequence in a tracker class. The tracker computes every
// expected report and compares it with each accepted result. A directed
// sweep covers the edges, fills the sequence and checks ties. Random phases
// at several stage counts follow, with random gaps and stalls on both
// channels in all but two of them.
// ============================================================================
module flow_shop_insertion_makespan_core_tb;
    import fsim_pkg::*;

    localparam int JOBS       = 64;
    localparam int STAGES     = 32;
    localparam int CLK_PERIOD = 4;
    localparam int SEQ_CAP    = 12;

    localparam logic [CMD_W-1:0] CMD_NONE = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [JOB_W-1:0]  job_id;
        logic [MACH_W-1:0] machine_index;
        logic [TIME_W-1:0] time_value;
        logic [POS_W-1:0]  position;
    } cmd_item_t;

    typedef struct packed {
        logic [SPAN_W-1:0] makespan;
        logic [POS_W-1:0]  best_position;
        logic [SPAN_W-1:0] worst_makespan;
        logic [STAT_W-1:0] status;
    } res_item_t;

    class flow_shop_tracker;
        logic [TIME_W-1:0] proc_time [JOBS][STAGES];
        bit                written [JOBS][STAGES];
        logic [JOB_W-1:0]  job_order [JOBS];
        int                order_len;
        logic [CFG_W-1:0]  stage_cfg;
        res_item_t         pending_reports [$];
        int                errors;

        function new();
            foreach (proc_time[i, j]) begin
                proc_time[i][j] = '0;
                written[i][j] = 1'b0;
            end
            foreach (job_order[i]) job_order[i] = '0;
            order_len = 0;
            stage_cfg = 6'd1;
            errors = 0;
        endfunction

        function void set_stage_count(logic [CFG_W-1:0] value);
            stage_cfg = value;
        endfunction

        function int active_stages();
            if (stage_cfg == 0) return 1;
            if (stage_cfg > STAGES) return STAGES;
            return int'(stage_cfg);
        endfunction

        // Makespan of the sequence, with the extra job placed at the given
        // slot when with_job is set.
        function int span_with_slot(bit with_job, int job, int slot);
            int row [STAGES];
            int m;
            int total;
            int cur;
            int prev;
            int c;
            m = active_stages();
            total = order_len + (with_job ? 1 : 0);
            foreach (row[j]) row[j] = 0;
            for (int k = 0; k < total; k++) begin
                if (!with_job || k < slot) cur = int'(job_order[k]);
                else if (k == slot) cur = job;
                else cur = int'(job_order[k - 1]);
                prev = 0;
                for (int j = 0; j < m; j++) begin
                    c = (row[j] > prev ? row[j] : prev) + int'(proc_time[cur][j]);
                    row[j] = c;
                    prev = c;
                end
            end
            if (total == 0) return 0;
            return row[m - 1] & 32'h7F_FFFF;
        endfunction

        function void note_command(cmd_item_t c);
            res_item_t r;
            int span_lo;
            int span_hi;
            int slot_lo;
            int t;
            r = '0;
            case (c.command)
                CMD_WRITE: begin
                    proc_time[c.job_id][c.machine_index] = c.time_value;
                    written[c.job_id][c.machine_index] = 1'b1;
                end
                CMD_CLEAR: begin
                    order_len = 0;
                end
                CMD_APPEND: begin
                    if (order_len >= JOBS) begin
                        r.status = ST_FULL;
                    end else begin
                        job_order[order_len] = c.job_id;
                        order_len++;
                    end
                end
                CMD_INSERT: begin
                    if (order_len >= JOBS) begin
                        r.status = ST_FULL;
                    end else if (int'(c.position) > order_len) begin
                        r.status = ST_RANGE;
                    end else begin
                        for (int k = order_len; k > int'(c.position); k--)
                            job_order[k] = job_order[k - 1];
                        job_order[c.position] = c.job_id;
                        order_len++;
                    end
                end
                CMD_REMOVE: begin
                    if (int'(c.position) >= order_len) begin
                        r.status = ST_RANGE;
                    end else begin
                        for (int k = int'(c.position); k + 1 < order_len; k++)
                            job_order[k] = job_order[k + 1];
                        order_len--;
                    end
                end
                CMD_MAKESPAN: begin
                    r.makespan = SPAN_W'(span_with_slot(1'b0, 0, 0));
                end
                CMD_BEST: begin
                    if (order_len >= JOBS) begin
                        r.status = ST_FULL;
                    end else begin
                        span_lo = 0;
                        span_hi = 0;
                        slot_lo = 0;
                        for (int k = 0; k <= order_len; k++) begin
                            t = span_with_slot(1'b1, int'(c.job_id), k);
                            if (k == 0 || t < span_lo) begin
                                span_lo = t;
                                slot_lo = k;
                            end
                            if (t > span_hi) span_hi = t;
                        end
                        r.makespan = SPAN_W'(span_lo);
                        r.best_position = POS_W'(slot_lo);
                        r.worst_makespan = SPAN_W'(span_hi);
                    end
                end
                default: begin
                end
            endcase
            pending_reports.push_back(r);
        endfunction

        function void check_result(res_item_t got);
            res_item_t want;
            if (pending_reports.size() == 0) begin
                $error("result transfer with no command outstanding: makespan %0d status %0d",
                       got.makespan, got.status);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            if (got.makespan !== want.makespan) begin
                $error("makespan: expected %0d, got %0d", want.makespan, got.makespan);
                errors++;
            end
            if (got.best_position !== want.best_position) begin
                $error("best_position: expected %0d, got %0d",
                       want.best_position, got.best_position);
                errors++;
            end
            if (got.worst_makespan !== want.worst_makespan) begin
                $error("worst_makespan: expected %0d, got %0d",
                       want.worst_makespan, got.worst_makespan);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;
    bit               idling = 1'b1;

    fsim_cmd_if cmd_if ();
    fsim_res_if res_if ();

    flow_shop_tracker shop = new();

    flow_shop_insertion_makespan_core #(
        .MAX_JOBS     (JOBS),
        .MAX_MACHINES (STAGES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd_if.sink),
        .o_res         (res_if.source)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (idling && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 16);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            shop.check_result({res_if.makespan, res_if.best_position,
                               res_if.worst_makespan, res_if.status});
    end

    function automatic cmd_item_t make_item(logic [CMD_W-1:0] cmd, int job, int mach,
                                            int tval, int pos);
        cmd_item_t c;
        c.command = cmd;
        c.job_id = JOB_W'(job);
        c.machine_index = MACH_W'(mach);
        c.time_value = TIME_W'(tval);
        c.position = POS_W'(pos);
        return c;
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3, 4: return TIME_W'($urandom_range(0, 20));
            default: return TIME_W'($urandom);
        endcase
    endfunction

    // A small job pool keeps the number of time writes low; wide stage
    // counts use a single job.
    function automatic int pick_job();
        if (shop.active_stages() > 8) return 0;
        return $urandom_range(0, 1);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input cmd_item_t c);
        if (idling && $urandom_range(0, 5) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= c.command;
        cmd_if.job_id        <= c.job_id;
        cmd_if.machine_index <= c.machine_index;
        cmd_if.time_value    <= c.time_value;
        cmd_if.position      <= c.position;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        shop.note_command(c);
        @(negedge i_clk);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (shop.pending_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_stage_count(input logic [CFG_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shop.set_stage_count(value);
    endtask

    // Every time that an evaluation reads must have been written first.
    task automatic fill_times(input int job);
        for (int j = 0; j < shop.active_stages(); j++) begin
            if (!shop.written[job][j])
                send_item(make_item(CMD_WRITE, job, j, pick_time(), $urandom));
        end
    endtask

    task automatic random_command();
        cmd_item_t c;
        int pick;
        int len;
        c = make_item(CMD_NONE, pick_job(), $urandom_range(0, STAGES - 1),
                      pick_time(), $urandom);
        pick = $urandom_range(0, 99);
        len = shop.order_len;
        if (pick < 18) c.command = CMD_WRITE;
        else if (pick < 22) c.command = CMD_CLEAR;
        else if (pick < 40) c.command = CMD_APPEND;
        else if (pick < 55) c.command = CMD_INSERT;
        else if (pick < 67) c.command = CMD_REMOVE;
        else if (pick < 80) c.command = CMD_MAKESPAN;
        else if (pick < 96) c.command = CMD_BEST;
        if (len >= SEQ_CAP && (c.command == CMD_APPEND || c.command == CMD_INSERT))
            c.command = CMD_REMOVE;
        case (c.command)
            CMD_WRITE: begin
                if ($urandom_range(0, 9) < 7)
                    c.machine_index = MACH_W'($urandom_range(0, shop.active_stages() - 1));
            end
            CMD_INSERT: begin
                if ($urandom_range(0, 19) < 17) c.position = POS_W'($urandom_range(0, len));
            end
            CMD_REMOVE: begin
                if (len > 0 && $urandom_range(0, 19) < 17)
                    c.position = POS_W'($urandom_range(0, len - 1));
            end
            CMD_MAKESPAN: begin
                for (int k = 0; k < len; k++) fill_times(int'(shop.job_order[k]));
            end
            CMD_BEST: begin
                for (int k = 0; k < len; k++) fill_times(int'(shop.job_order[k]));
                fill_times(int'(c.job_id));
            end
            default: begin
            end
        endcase
        send_item(c);
    endtask

    initial begin
        logic [CFG_W-1:0] phase_cfg [6];
        phase_cfg = '{6'd4, 6'd0, 6'd7, 6'd32, 6'd63, 6'd5};
        i_rst_n              = 1'b0;
        i_cfg_wr_en          = 1'b0;
        i_cfg_wr_data        = '0;
        cmd_if.valid         = 1'b0;
        cmd_if.command       = '0;
        cmd_if.job_id        = '0;
        cmd_if.machine_index = '0;
        cmd_if.time_value    = '0;
        cmd_if.position      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        write_stage_count(6'd2);
        send_item(make_item(CMD_MAKESPAN, 0, 0, 0, 0));
        send_item(make_item(CMD_WRITE, 63, 0, 16'hFFFF, 0));
        send_item(make_item(CMD_WRITE, 63, 1, 16'hFFFF, 127));
        send_item(make_item(CMD_WRITE, 0, 0, 0, 0));
        send_item(make_item(CMD_WRITE, 0, 1, 0, 0));
        send_item(make_item(CMD_NONE, 63, 31, 16'hFFFF, 127));
        send_item(make_item(CMD_BEST, 0, 0, 0, 0));
        send_item(make_item(CMD_REMOVE, 0, 0, 0, 0));
        send_item(make_item(CMD_INSERT, 63, 0, 0, 1));
        send_item(make_item(CMD_INSERT, 63, 0, 0, 0));
        repeat (JOBS - 1) send_item(make_item(CMD_APPEND, 63, 0, 0, 0));
        send_item(make_item(CMD_MAKESPAN, 0, 0, 0, 0));
        send_item(make_item(CMD_APPEND, 0, 0, 0, 0));
        send_item(make_item(CMD_INSERT, 0, 0, 0, 0));
        send_item(make_item(CMD_BEST, 0, 0, 0, 0));
        send_item(make_item(CMD_REMOVE, 0, 0, 0, 64));
        send_item(make_item(CMD_REMOVE, 0, 0, 0, 127));
        send_item(make_item(CMD_REMOVE, 0, 0, 0, 63));
        send_item(make_item(CMD_INSERT, 0, 0, 0, 64));
        send_item(make_item(CMD_BEST, 0, 0, 0, 0));
        send_item(make_item(CMD_INSERT, 0, 0, 0, 63));
        send_item(make_item(CMD_REMOVE, 0, 0, 0, 0));
        send_item(make_item(CMD_MAKESPAN, 0, 0, 0, 0));
        send_item(make_item(CMD_CLEAR, 0, 0, 0, 0));
        send_item(make_item(CMD_MAKESPAN, 0, 0, 0, 0));

        for (int p = 0; p < 6; p++) begin
            drain();
            if (p == 5) phase_cfg[p] = CFG_W'($urandom_range(2, 8));
            write_stage_count(phase_cfg[p]);
            idling = (p != 2 && p != 5);
            if (p == 3) send_item(make_item(CMD_CLEAR, 0, 0, 0, 0));
            repeat (5) random_command();
        end
        drain();
        repeat (20) @(posedge i_clk);

        if (shop.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[sim.f]
sv/fsim_pkg.sv
sv/fsim_cmd_if.sv
sv/fsim_res_if.sv
sv/fsim_time_mem.sv
sv/fsim_cell.sv
sv/flow_shop_insertion_makespan_core.sv
bench/flow_shop_insertion_makespan_core_tb.sv
